// File: hw/rtl/scp_pkg.sv
// Shared constants, word types and the helper function of the servo pulse generator.
package scp_pkg;

   // Channel and command geometry.
   localparam int Channels     = 8;
   localparam int CommandChars = 4;
   localparam int PinCount     = 8;
   localparam int ChanW        = (Channels > 1) ? $clog2(Channels) : 1;
   localparam int CharCountW   = $clog2(CommandChars + 1);
   localparam int BufIdxW      = $clog2(CommandChars);

   // Character codes and angle limits.
   localparam logic [7:0] AsciiZero   = 8'd48;
   localparam logic [7:0] NewlineChar = 8'd10;
   localparam logic [7:0] MaxAngle    = 8'd180;

   // Reset values of the width store and of the control registers.
   localparam logic [15:0] ResetWidth     = 16'd2775;
   localparam logic [15:0] ResetPeriodTop = 16'd39999;
   localparam logic [15:0] ResetPulseBase = 16'd1050;
   localparam logic [15:0] ResetPulseSpan = 16'd3450;

   // Scaling datapath: (angle * span + 90) / 180, done as ((x >> 2) * M) >> 28,
   // where M = ceil(2^28 / 45) is exact for every quotient below 2^22.
   localparam int              ProductW   = 24;
   localparam logic [23:0]     RoundHalf  = 24'd90;
   localparam int              QuarterW   = ProductW - 2;
   localparam int              RecipW     = 23;
   localparam logic [22:0]     RecipMul   = 23'd5965233;
   localparam int              RecipShift = 28;
   localparam int              RecipProdW = QuarterW + RecipW;

   // Control register indexes.
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type RegPeriodTop = 2'd0;
   localparam csr_index_type RegPulseBase = 2'd1;
   localparam csr_index_type RegPulseSpan = 2'd2;

   // Word leaving the character front end.
   typedef struct packed {
      logic [15:0]      count;
      logic [7:0]       angle;
      logic [ChanW-1:0] chan;
      logic             write_en;
      logic             applied;
      logic             rejected;
   } cmd_token_type;

   // Word travelling along the channel cells.
   typedef struct packed {
      logic [15:0]         count;
      logic [15:0]         width;
      logic [ChanW-1:0]    chan;
      logic                write_en;
      logic                applied;
      logic                rejected;
      logic [PinCount-1:0] pins;
   } cell_token_type;

   // True for the ASCII characters zero through nine.
   function automatic logic is_digit(logic [7:0] c);
      return (c >= AsciiZero) && (c <= (AsciiZero + 8'd9));
   endfunction

endpackage

// File: hw/rtl/scp_if.sv
// Handshake channel interfaces of the servo pulse generator.
interface scp_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, op, rx_byte, input ready);
   modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface scp_rsp_if import scp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PinCount-1:0] servo_pins;
   logic                command_applied;
   logic                command_rejected;

   modport source (output valid, servo_pins, command_applied, command_rejected, input ready);
   modport sink   (input valid, servo_pins, command_applied, command_rejected, output ready);
endinterface

interface scp_csr_if import scp_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [15:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/scp_front.sv
// Front end: period counter, command character buffer and command decode.
module scp_front import scp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [15:0]   period_top,
   input  logic          in_valid,
   input  logic          in_op,
   input  logic [7:0]    in_rx_byte,
   output logic          in_ready,
   output logic          out_valid,
   output cmd_token_type out_tok,
   input  logic          out_ready
);

   logic [15:0]           count_ff, count_in;
   logic [7:0]            buf_ff [CommandChars];
   logic [7:0]            buf_in [CommandChars];
   logic [CharCountW-1:0] char_count_ff, char_count_in;
   logic                  valid_ff, valid_in;
   cmd_token_type         tok_ff, tok_in;

   logic                  accept;
   logic                  store;
   logic                  ending;
   logic                  full;
   logic                  all_digits;
   logic [9:0]            angle_wide;
   logic [3:0]            chan_digit;
   logic                  cmd_ok;
   logic [15:0]           count_next;
   cmd_token_type         tok;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

   // Counter advance on a tick, wrapping after the top value.
   assign count_next = (count_ff >= period_top) ? 16'd0 : count_ff + 16'd1;

   // Byte classification: store while room is left and the byte is not a newline, otherwise end the command.
   assign full   = (char_count_ff == CharCountW'(CommandChars));
   assign store  = in_op && !full && (in_rx_byte != NewlineChar);
   assign ending = in_op && !store;

   // Decode the four collected characters; a digit's value is its low nibble.
   always_comb begin
      all_digits = 1'b1;
      for (int i = 0; i < CommandChars; i++) begin
         all_digits = all_digits && is_digit(buf_ff[i]);
      end
      angle_wide = 10'(buf_ff[0][3:0]) * 10'd100 + 10'(buf_ff[1][3:0]) * 10'd10
                 + 10'(buf_ff[2][3:0]);
      chan_digit = buf_ff[3][3:0];
      cmd_ok     = full && all_digits && (angle_wide <= 10'(MaxAngle))
                && ({1'b0, chan_digit} < 5'(Channels));
   end

   // Word handed to the scaling pipeline.
   always_comb begin
      tok          = '0;
      tok.count    = in_op ? count_ff : count_next;
      tok.angle    = angle_wide[7:0];
      tok.chan     = ChanW'(chan_digit);
      tok.applied  = ending && cmd_ok;
      tok.rejected = ending && (char_count_ff != '0) && !cmd_ok;
      tok.write_en = ending && cmd_ok;
   end

   // Next state of the counter, buffer and output stage.
   always_comb begin
      count_in      = count_ff;
      char_count_in = char_count_ff;
      for (int i = 0; i < CommandChars; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (accept) begin
         if (!in_op) begin
            count_in = count_next;
         end else if (store) begin
            buf_in[char_count_ff[BufIdxW-1:0]] = in_rx_byte;
            char_count_in = char_count_ff + CharCountW'(1);
         end else begin
            char_count_in = '0;
         end
      end
      valid_in = in_ready ? in_valid : valid_ff;
      tok_in   = accept ? tok : tok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         char_count_ff <= '0;
         valid_ff      <= 1'b0;
         for (int i = 0; i < CommandChars; i++) begin
            buf_ff[i] <= '0;
         end
      end else begin
         count_ff      <= count_in;
         char_count_ff <= char_count_in;
         valid_ff      <= valid_in;
         for (int i = 0; i < CommandChars; i++) begin
            buf_ff[i] <= buf_in[i];
         end
      end
      tok_ff <= tok_in;
   end

endmodule

// File: hw/rtl/scp_scale.sv
// Three-stage pipeline that turns an angle into a saturated pulse width.
module scp_scale import scp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [15:0]    pulse_base,
   input  logic [15:0]    pulse_span,
   input  logic           in_valid,
   input  cmd_token_type  in_tok,
   output logic           in_ready,
   output logic           out_valid,
   output cell_token_type out_tok,
   input  logic           out_ready
);

   logic                  v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                  r1, r2, r3;
   cmd_token_type         meta1_ff, meta1_in, meta2_ff, meta2_in;
   logic [ProductW-1:0]   prod_ff, prod_in;
   logic [15:0]           scaled_ff, scaled_in;
   cell_token_type        tok3_ff, tok3_in;
   logic [RecipProdW-1:0] recip_prod;
   logic [16:0]           sum;

   // Each stage takes a word when it is empty or its word moves on.
   assign r3       = !v3_ff || out_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   assign out_valid = v3_ff;
   assign out_tok   = tok3_ff;

   // Stage one: angle times span plus half the divisor.
   assign prod_in  = (in_valid && r1) ? ProductW'(in_tok.angle) * ProductW'(pulse_span) + RoundHalf
                                      : prod_ff;
   assign meta1_in = (in_valid && r1) ? in_tok : meta1_ff;
   assign v1_in    = r1 ? in_valid : v1_ff;

   // Stage two: divide by 180 through a reciprocal multiply of the quarter.
   assign recip_prod = RecipProdW'(prod_ff[ProductW-1:2]) * RecipProdW'(RecipMul);
   assign scaled_in  = (v1_ff && r2) ? recip_prod[RecipShift+15:RecipShift] : scaled_ff;
   assign meta2_in   = (v1_ff && r2) ? meta1_ff : meta2_ff;
   assign v2_in      = r2 ? v1_ff : v2_ff;

   // Stage three: add the base and saturate at full scale.
   assign sum = {1'b0, pulse_base} + {1'b0, scaled_ff};
   always_comb begin
      tok3_in = tok3_ff;
      if (v2_ff && r3) begin
         tok3_in          = '0;
         tok3_in.count    = meta2_ff.count;
         tok3_in.width    = sum[16] ? 16'hFFFF : sum[15:0];
         tok3_in.chan     = meta2_ff.chan;
         tok3_in.write_en = meta2_ff.write_en;
         tok3_in.applied  = meta2_ff.applied;
         tok3_in.rejected = meta2_ff.rejected;
      end
   end
   assign v3_in = r3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      prod_ff   <= prod_in;
      meta1_ff  <= meta1_in;
      scaled_ff <= scaled_in;
      meta2_ff  <= meta2_in;
      tok3_ff   <= tok3_in;
   end

endmodule

// File: hw/rtl/scp_cell.sv
// One channel cell: holds that channel's pulse width and adds its pin to the passing word.
module scp_cell import scp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [ChanW-1:0] cell_index,
   input  logic             in_valid,
   input  cell_token_type   in_tok,
   output logic             in_ready,
   output logic             out_valid,
   output cell_token_type   out_tok,
   input  logic             out_ready
);

   logic [15:0]         width_ff, width_in;
   logic                valid_ff, valid_in;
   cell_token_type      tok_ff, tok_in;
   logic                accept;
   logic                hit;
   logic [15:0]         width_now;
   logic [PinCount-1:0] pin_mask;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

   // A command word for this channel replaces the width before the compare.
   assign hit       = in_tok.write_en && (in_tok.chan == cell_index);
   assign width_now = hit ? in_tok.width : width_ff;

   // Channels past the last pin shift their bit out of the mask.
   assign pin_mask = PinCount'(1) << cell_index;

   always_comb begin
      width_in = (accept && hit) ? in_tok.width : width_ff;
      valid_in = in_ready ? in_valid : valid_ff;
      tok_in   = tok_ff;
      if (accept) begin
         tok_in = in_tok;
         if (width_now > in_tok.count) begin
            tok_in.pins = in_tok.pins | pin_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= ResetWidth;
         valid_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         valid_ff <= valid_in;
      end
      tok_ff <= tok_in;
   end

endmodule

// File: hw/rtl/serial_commanded_servo_pwm_top.sv
// Top level of the serial-commanded eight-channel servo pulse generator.
//
// Each request word is a timer tick or a received character; every word yields exactly one
// response word carrying the pin levels after that word's update and the command flags.
// One word is accepted per clock when the response side keeps up. A word passes through
// Channels + 4 register stages (12 for eight channels): one in the character front end,
// three in the angle scaling pipeline (multiply, reciprocal divide, saturating add), and one
// in each channel cell of the chain that holds the widths and builds the pin word. Its
// response is presented from the last cell's register.
// Every stage has its own valid bit, so bubbles collapse and words keep entering while a
// finished response waits. Control registers are written at any time through the csr port,
// which is always ready; change them only while no word is in flight. No clearing pass is
// needed after reset.
module serial_commanded_servo_pwm_top import scp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   scp_req_if.sink   req_port,
   scp_rsp_if.source rsp_port,
   scp_csr_if.sink   csr_port
);

   logic [15:0]    period_top_ff, period_top_in;
   logic [15:0]    pulse_base_ff, pulse_base_in;
   logic [15:0]    pulse_span_ff, pulse_span_in;

   logic           front_valid, front_ready;
   cmd_token_type  front_tok;

   logic           chain_valid [Channels+1];
   logic           chain_ready [Channels+1];
   cell_token_type chain_tok   [Channels+1];

   // Control register writes.
   assign csr_port.ready = 1'b1;
   always_comb begin
      period_top_in = period_top_ff;
      pulse_base_in = pulse_base_ff;
      pulse_span_in = pulse_span_ff;
      if (csr_port.valid) begin
         unique case (csr_port.index)
            RegPeriodTop: period_top_in = csr_port.data;
            RegPulseBase: pulse_base_in = csr_port.data;
            RegPulseSpan: pulse_span_in = csr_port.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_top_ff <= ResetPeriodTop;
         pulse_base_ff <= ResetPulseBase;
         pulse_span_ff <= ResetPulseSpan;
      end else begin
         period_top_ff <= period_top_in;
         pulse_base_ff <= pulse_base_in;
         pulse_span_ff <= pulse_span_in;
      end
   end

   // Character front end and counter.
   scp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .period_top (period_top_ff),
      .in_valid   (req_port.valid),
      .in_op      (req_port.op),
      .in_rx_byte (req_port.rx_byte),
      .in_ready   (req_port.ready),
      .out_valid  (front_valid),
      .out_tok    (front_tok),
      .out_ready  (front_ready)
   );

   // Angle to pulse width scaling.
   scp_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .pulse_base (pulse_base_ff),
      .pulse_span (pulse_span_ff),
      .in_valid   (front_valid),
      .in_tok     (front_tok),
      .in_ready   (front_ready),
      .out_valid  (chain_valid[0]),
      .out_tok    (chain_tok[0]),
      .out_ready  (chain_ready[0])
   );

   // Chain of channel cells; the last cell's register is the response register.
   for (genvar n = 0; n < Channels; n++) begin : g_cell
      scp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (ChanW'(n)),
         .in_valid   (chain_valid[n]),
         .in_tok     (chain_tok[n]),
         .in_ready   (chain_ready[n]),
         .out_valid  (chain_valid[n+1]),
         .out_tok    (chain_tok[n+1]),
         .out_ready  (chain_ready[n+1])
      );
   end

   // Response word.
   assign rsp_port.valid            = chain_valid[Channels];
   assign chain_ready[Channels]     = rsp_port.ready;
   assign rsp_port.servo_pins       = chain_tok[Channels].pins;
   assign rsp_port.command_applied  = chain_tok[Channels].applied;
   assign rsp_port.command_rejected = chain_tok[Channels].rejected;

endmodule
